@@ rtl/k_hop_bfs_neighbour_finder_macros.svh @@
// ----------------------------------------------------------------------------
// k_hop_bfs_neighbour_finder_macros
// Assertion shorthands for the neighbour finder checker. Each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef K_HOP_BFS_NEIGHBOUR_FINDER_MACROS_SVH
`define K_HOP_BFS_NEIGHBOUR_FINDER_MACROS_SVH

// Same-cycle implication, off during reset
`define KHBFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define KHBFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/khbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// khbfs_pkg
// Shared widths, codes and the result record of the k-hop neighbour finder.
// ----------------------------------------------------------------------------
package khbfs_pkg;

    localparam int NODES_DEF      = 64;
    localparam int MAX_DEGREE_DEF = 16;

    localparam int NODE_PW   = 6;
    localparam int HOP_PW    = 7;
    localparam int STATUS_PW = 2;

    // Function codes of an input item
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_PW-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_PW-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_PW-1:0] ST_FOUND = 2'd2;
    localparam logic [STATUS_PW-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic [STATUS_PW-1:0] status;
        logic [NODE_PW-1:0]   found_node;
        logic [NODE_PW-1:0]   hop_level;
        logic                 last;
    } res_t;

endpackage

@@ rtl/k_hop_bfs_neighbour_finder.sv @@
// ----------------------------------------------------------------------------
// k_hop_bfs_neighbour_finder
// Undirected graph store with a hop-limited breadth-first search engine.
// ----------------------------------------------------------------------------
// After reset the block sweeps its degree counts, one node a cycle, before it
// takes the first item. An add item gives one result. A query item first
// clears the visited marks, then reads the stored neighbours of every node it
// expands and queues each node reached for the first time, then gives its
// results; all steps share memories with one read and one write port each,
// driven by one sequencer. The input side is not ready while an item is in
// work; a finished result waits in an output register, so the next item may
// start before the consumer takes it.
// ----------------------------------------------------------------------------
module k_hop_bfs_neighbour_finder
    import khbfs_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [NODE_PW-1:0]   node_a,
    input  logic [NODE_PW-1:0]   node_b,
    input  logic [HOP_PW-1:0]    hop_limit,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_PW-1:0] status,
    output logic [NODE_PW-1:0]   found_node,
    output logic [NODE_PW-1:0]   hop_level,
    output logic                 last
);

    localparam int NW = $clog2(NODES);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int TW = $clog2(NODES * MAX_DEGREE);
    localparam int CW = (NW > HOP_PW) ? NW : HOP_PW;

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_ADD_RA   = 5'd2;
    localparam logic [4:0] S_ADD_RB   = 5'd3;
    localparam logic [4:0] S_ADD_CHK  = 5'd4;
    localparam logic [4:0] S_ADD_W2   = 5'd5;
    localparam logic [4:0] S_RES      = 5'd6;
    localparam logic [4:0] S_QCLR     = 5'd7;
    localparam logic [4:0] S_QSRC     = 5'd8;
    localparam logic [4:0] S_EXP_CNT  = 5'd9;
    localparam logic [4:0] S_EXP_CNTW = 5'd10;
    localparam logic [4:0] S_EXP_RD   = 5'd11;
    localparam logic [4:0] S_EXP_VR   = 5'd12;
    localparam logic [4:0] S_EXP_VC   = 5'd13;
    localparam logic [4:0] S_DEQ      = 5'd14;
    localparam logic [4:0] S_DEQW     = 5'd15;
    localparam logic [4:0] S_EMIT_SET = 5'd16;
    localparam logic [4:0] S_EMIT_RD  = 5'd17;
    localparam logic [4:0] S_EMIT_WR  = 5'd18;

    // Memories
    logic [NW-1:0] tbl_mem [NODES*MAX_DEGREE];
    logic [DW-1:0] cnt_mem [NODES];
    logic          vis_mem [NODES];
    logic [NW-1:0] q_mem   [NODES];
    logic [NW-1:0] lvl_mem [NODES];

    logic          tbl_we, cnt_we, vis_we, q_we;
    logic [TW-1:0] tbl_wa, tbl_ra;
    logic [NW-1:0] tbl_wd, cnt_wa, cnt_ra, vis_wa, vis_ra, q_ra;
    logic [DW-1:0] cnt_wd;
    logic          vis_wd;
    logic [NW-1:0] tbl_rd, q_rd, l_rd;
    logic [DW-1:0] cnt_rd;
    logic          vis_rd;

    // Sequencer registers
    logic [4:0]        state_reg, state_next;
    logic [NW-1:0]     clr_reg, clr_next;
    logic [NW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [HOP_PW-1:0] k_reg, k_next;
    logic [DW-1:0]     ca_reg, ca_next, deg_reg, deg_next, i_reg, i_next;
    logic [NW-1:0]     cur_reg, cur_next, lvl_reg, lvl_next;
    logic [NW-1:0]     head_reg, head_next, tail_reg, tail_next, idx_reg, idx_next;
    logic [STATUS_PW-1:0] rst_reg, rst_next;

    logic a_ok, b_ok, add_ok, out_free, ld;
    res_t ld_data;

    assign a_ok = 32'(node_a) < NODES;
    assign b_ok = 32'(node_b) < NODES;

    // Add fits when both lists have room; a self loop needs two slots
    always_comb
    begin
        if (a_reg == b_reg)
        begin
            add_ok = ({1'b0, ca_reg} + (DW+1)'(2)) <= (DW+1)'(MAX_DEGREE);
        end
        else
        begin
            add_ok = (ca_reg < DW'(MAX_DEGREE)) && (cnt_rd < DW'(MAX_DEGREE));
        end
    end

    // Memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rd <= tbl_mem[tbl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_wa] <= vis_wd;
        end
        vis_rd <= vis_mem[vis_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg]   <= tbl_rd;
            lvl_mem[tail_reg] <= NW'(lvl_reg + 1'b1);
        end
        q_rd <= q_mem[q_ra];
        l_rd <= lvl_mem[q_ra];
    end

    assign in_stall = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        ca_next    = ca_reg;
        deg_next   = deg_reg;
        i_next     = i_reg;
        cur_next   = cur_reg;
        lvl_next   = lvl_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        idx_next   = idx_reg;
        rst_next   = rst_reg;
        tbl_we     = 1'b0;
        tbl_wa     = TW'(32'(a_reg) * MAX_DEGREE + 32'(ca_reg));
        tbl_wd     = b_reg;
        tbl_ra     = TW'(32'(cur_reg) * MAX_DEGREE + 32'(i_reg));
        cnt_we     = 1'b0;
        cnt_wa     = a_reg;
        cnt_wd     = DW'(ca_reg + 1'b1);
        cnt_ra     = a_reg;
        vis_we     = 1'b0;
        vis_wa     = tbl_rd;
        vis_wd     = 1'b1;
        vis_ra     = tbl_rd;
        q_we       = 1'b0;
        // Keep the result entry addressed while it waits for the output slot
        q_ra       = (state_reg == S_EMIT_RD || state_reg == S_EMIT_WR) ? idx_reg : head_reg;
        ld         = 1'b0;
        ld_data    = '{status: rst_reg, found_node: '0, hop_level: '0, last: 1'b1};

        unique case (state_reg)
            S_INIT:
            begin
                cnt_we = 1'b1;
                cnt_wa = clr_reg;
                cnt_wd = '0;
                if (clr_reg == NW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = NW'(clr_reg + 1'b1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = NW'(node_a);
                    b_next = NW'(node_b);
                    k_next = hop_limit;
                    if (func == FUNC_ADD)
                    begin
                        if (a_ok && b_ok)
                        begin
                            state_next = S_ADD_RA;
                        end
                        else
                        begin
                            rst_next   = ST_FULL;
                            state_next = S_RES;
                        end
                    end
                    else if (!a_ok || hop_limit == '0)
                    begin
                        rst_next   = ST_NONE;
                        state_next = S_RES;
                    end
                    else
                    begin
                        clr_next   = '0;
                        state_next = S_QCLR;
                    end
                end
            end
            S_ADD_RA:
            begin
                state_next = S_ADD_RB;
            end
            S_ADD_RB:
            begin
                ca_next    = cnt_rd;
                cnt_ra     = b_reg;
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                if (add_ok)
                begin
                    tbl_we     = 1'b1;
                    cnt_we     = 1'b1;
                    deg_next   = (a_reg == b_reg) ? DW'(ca_reg + 1'b1) : cnt_rd;
                    state_next = S_ADD_W2;
                end
                else
                begin
                    rst_next   = ST_FULL;
                    state_next = S_RES;
                end
            end
            S_ADD_W2:
            begin
                tbl_we     = 1'b1;
                tbl_wa     = TW'(32'(b_reg) * MAX_DEGREE + 32'(deg_reg));
                tbl_wd     = a_reg;
                cnt_we     = 1'b1;
                cnt_wa     = b_reg;
                cnt_wd     = DW'(deg_reg + 1'b1);
                rst_next   = ST_ADDED;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QCLR:
            begin
                vis_we = 1'b1;
                vis_wa = clr_reg;
                vis_wd = 1'b0;
                if (clr_reg == NW'(NODES - 1))
                begin
                    state_next = S_QSRC;
                end
                else
                begin
                    clr_next = NW'(clr_reg + 1'b1);
                end
            end
            S_QSRC:
            begin
                vis_we     = 1'b1;
                vis_wa     = a_reg;
                cur_next   = a_reg;
                lvl_next   = '0;
                head_next  = '0;
                tail_next  = '0;
                state_next = S_EXP_CNT;
            end
            S_EXP_CNT:
            begin
                cnt_ra     = cur_reg;
                state_next = S_EXP_CNTW;
            end
            S_EXP_CNTW:
            begin
                deg_next   = cnt_rd;
                i_next     = '0;
                state_next = S_EXP_RD;
            end
            S_EXP_RD:
            begin
                state_next = (i_reg == deg_reg) ? S_DEQ : S_EXP_VR;
            end
            S_EXP_VR:
            begin
                state_next = S_EXP_VC;
            end
            S_EXP_VC:
            begin
                // Enqueue a neighbour seen for the first time
                if (!vis_rd)
                begin
                    vis_we    = 1'b1;
                    q_we      = 1'b1;
                    tail_next = NW'(tail_reg + 1'b1);
                end
                i_next     = DW'(i_reg + 1'b1);
                state_next = S_EXP_RD;
            end
            S_DEQ:
            begin
                state_next = (head_reg == tail_reg) ? S_EMIT_SET : S_DEQW;
            end
            S_DEQW:
            begin
                // Stop at the first node beyond the hop limit
                if (CW'(l_rd) > CW'(k_reg))
                begin
                    state_next = S_EMIT_SET;
                end
                else
                begin
                    cur_next   = q_rd;
                    lvl_next   = l_rd;
                    head_next  = NW'(head_reg + 1'b1);
                    state_next = S_EXP_CNT;
                end
            end
            S_EMIT_SET:
            begin
                if (head_reg == '0)
                begin
                    rst_next   = ST_NONE;
                    state_next = S_RES;
                end
                else
                begin
                    idx_next   = NW'(head_reg - 1'b1);
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                ld_data = '{status: ST_FOUND, found_node: NODE_PW'(q_rd),
                            hop_level: NODE_PW'(l_rd), last: (idx_reg == '0)};
                if (out_free)
                begin
                    ld = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = NW'(idx_reg - 1'b1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        ca_reg   <= ca_next;
        deg_reg  <= deg_next;
        i_reg    <= i_next;
        cur_reg  <= cur_next;
        lvl_reg  <= lvl_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        idx_reg  <= idx_next;
        rst_reg  <= rst_next;
    end

    khbfs_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ld),
        .load_data  (ld_data),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .found_node (found_node),
        .hop_level  (hop_level),
        .last       (last)
    );

endmodule

@@ rtl/khbfs_out_stage.sv @@
// ----------------------------------------------------------------------------
// khbfs_out_stage
// Output register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module khbfs_out_stage
    import khbfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  res_t                 load_data,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_PW-1:0] status,
    output logic [NODE_PW-1:0]   found_node,
    output logic [NODE_PW-1:0]   hop_level,
    output logic                 last
);

    logic valid_reg;
    res_t data_reg;

    // Slot can take a new item when empty or being drained this cycle
    assign free = !valid_reg || !out_stall;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid  = valid_reg;
    assign status     = data_reg.status;
    assign found_node = data_reg.found_node;
    assign hop_level  = data_reg.hop_level;
    assign last       = data_reg.last;

endmodule

@@ rtl/khbfs_checker.sv @@
// ----------------------------------------------------------------------------
// khbfs_checker
// Port-level checks on the neighbour finder input and result channels.
// ----------------------------------------------------------------------------
`include "k_hop_bfs_neighbour_finder_macros.svh"

module khbfs_checker
    import khbfs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [STATUS_PW-1:0] status,
    input logic [NODE_PW-1:0]   found_node,
    input logic [NODE_PW-1:0]   hop_level,
    input logic                 last
);

    // Stalled result item holds
    `KHBFS_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(found_node) && $stable(hop_level) && $stable(last), "stalled result changed")

    // An accepted input item makes the block busy
    `KHBFS_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall, "input not held off after accept")

    // Add and none-found results stand alone
    `KHBFS_ASSERT_IMP(a_single, out_valid && status != ST_FOUND, last, "lone result without last")

    // Only found results carry a node and level
    `KHBFS_ASSERT_IMP(a_zero, out_valid && status != ST_FOUND, found_node == '0 && hop_level == '0, "stray node fields")

    // Reached nodes are at least one hop away
    `KHBFS_ASSERT_IMP(a_level, out_valid && status == ST_FOUND, hop_level != '0, "found node at level zero")

endmodule

bind k_hop_bfs_neighbour_finder khbfs_checker u_khbfs_checker (.*);
